>>> rtl/pstp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_pkg
// Shared widths, register indexes and control types for the pivot-swap
// to permutation block.
// ----------------------------------------------------------------------------
package pstp_pkg;

   localparam int PIVOT_W      = 7;
   localparam int ROW_INDEX_W  = 6;
   localparam int SOURCE_ROW_W = 7;
   localparam int ROW_COUNT_W  = 7;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RESET = 7'd64;
   localparam logic [SOURCE_ROW_W-1:0] UNTOUCHED       = 7'h7F;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPOSED = 1'b1;

   typedef struct packed {
      logic piv_we;
      logic piv_re;
      logic map_we;
      logic map_re;
   } pstp_ram_ctl_type;

endpackage

>>> rtl/pstp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_if
// Valid/ready channels: pivot words in, permutation words out.
// ----------------------------------------------------------------------------
interface pstp_req_if import pstp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIVOT_W-1:0] pivot;

   modport source (output valid, output pivot, input ready);
   modport sink   (input valid, input pivot, output ready);
endinterface

interface pstp_rsp_if import pstp_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic        [ROW_INDEX_W-1:0]  row_index;
   logic signed [SOURCE_ROW_W-1:0] source_row;
   logic                           last_row;

   modport source (output valid, output row_index, output source_row, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input source_row, input last_row,
                   output ready);
endinterface

>>> rtl/pivot_swaps_to_permutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivot_swaps_to_permutation
// Collects one-based row-swap pivots, one per word, and once row_count
// pivots are in, applies them as full swaps to a row map (first to last,
// or last to first when transposed) and streams out the map, one word per
// row: the original row now at that position, or -1 if untouched.
// A pivot that does not complete the map is stored and the block stays
// ready for the next. The word that completes it starts a run of swaps,
// set by the single read port of the map RAM (two reads and two writes
// per swap), then a map read and one output word per cycle while the sink
// keeps up. The touched flags are cleared at the start of each run; there
// is no clearing pass after reset. A new pivot word is taken once the last
// map word sits in the output register.
// ----------------------------------------------------------------------------
module pivot_swaps_to_permutation import pstp_pkg::*; #(
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   pstp_req_if.sink               req_bus,
   pstp_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam logic [ROW_COUNT_W-1:0] ROWS_MAX = ROW_COUNT_W'(MAX_ROWS);

   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic                   transposed_ff;
   logic [IDX_W:0]         rows;

   pstp_ram_ctl_type       ram_ctl;
   logic [IDX_W-1:0]       piv_wr_addr, piv_wr_data, piv_rd_addr, piv_rd_data;
   logic [IDX_W-1:0]       map_wr_addr, map_wr_data, map_rd_addr, map_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= ROW_COUNT_RESET;
         transposed_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT:  row_count_ff  <= csr_wr_data;
            CSR_TRANSPOSED: transposed_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_count_ff == '0) begin
         rows = (IDX_W+1)'(1);
      end else if (row_count_ff > ROWS_MAX) begin
         rows = (IDX_W+1)'(MAX_ROWS);
      end else begin
         rows = (IDX_W+1)'(row_count_ff);
      end
   end

   pstp_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .rows        (rows),
      .transposed  (transposed_ff),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .ram_ctl     (ram_ctl),
      .piv_wr_addr (piv_wr_addr),
      .piv_wr_data (piv_wr_data),
      .piv_rd_addr (piv_rd_addr),
      .piv_rd_data (piv_rd_data),
      .map_wr_addr (map_wr_addr),
      .map_wr_data (map_wr_data),
      .map_rd_addr (map_rd_addr),
      .map_rd_data (map_rd_data)
   );

   pstp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ROWS)
   ) u_pivot_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.piv_we),
      .wr_addr (piv_wr_addr),
      .wr_data (piv_wr_data),
      .rd_en   (ram_ctl.piv_re),
      .rd_addr (piv_rd_addr),
      .rd_data (piv_rd_data)
   );

   pstp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (ram_ctl.map_re),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

endmodule

>>> rtl/pstp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pstp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pstp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_ctrl
// Load / swap / emit sequencer around the pivot and map RAMs, with the
// per-row touched flags and the output word register.
// ----------------------------------------------------------------------------
module pstp_ctrl import pstp_pkg::*; #(
   parameter int MAX_ROWS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [$clog2(MAX_ROWS):0]   rows,
   input  logic                        transposed,
   pstp_req_if.sink                    req_bus,
   pstp_rsp_if.source                  rsp_bus,
   output pstp_ram_ctl_type            ram_ctl,
   output logic [$clog2(MAX_ROWS)-1:0] piv_wr_addr,
   output logic [$clog2(MAX_ROWS)-1:0] piv_wr_data,
   output logic [$clog2(MAX_ROWS)-1:0] piv_rd_addr,
   input  logic [$clog2(MAX_ROWS)-1:0] piv_rd_data,
   output logic [$clog2(MAX_ROWS)-1:0] map_wr_addr,
   output logic [$clog2(MAX_ROWS)-1:0] map_wr_data,
   output logic [$clog2(MAX_ROWS)-1:0] map_rd_addr,
   input  logic [$clog2(MAX_ROWS)-1:0] map_rd_data
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam logic [PIVOT_W-1:0] PIVOT_MAX = PIVOT_W'(MAX_ROWS);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PIV    = 8'b0000_0010,
      ST_RDA    = 8'b0000_0100,
      ST_RDB    = 8'b0000_1000,
      ST_WRI    = 8'b0001_0000,
      ST_WRT    = 8'b0010_0000,
      ST_EMRD   = 8'b0100_0000,
      ST_EMWAIT = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [IDX_W:0]                 load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [IDX_W-1:0]               tgt_ff, tgt_in;
   logic [IDX_W-1:0]               a_ff, a_in;
   logic [MAX_ROWS-1:0]            touched_ff, touched_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ROW_INDEX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [SOURCE_ROW_W-1:0]        rsp_source_ff, rsp_source_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           req_fire;
   logic [IDX_W:0]                 cnt_next;
   logic [PIVOT_W-1:0]             pivot_m1;
   logic [IDX_W-1:0]               rows_m1;
   logic                           swap_last;
   logic [IDX_W-1:0]               swap_next;
   logic [IDX_W-1:0]               map_val;
   logic                           out_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign cnt_next      = load_cnt_ff + 1'b1;
   assign pivot_m1      = req_bus.pivot - 1'b1;
   assign rows_m1       = IDX_W'(rows - 1'b1);
   assign swap_last     = transposed ? (idx_ff == '0) : (idx_ff == rows_m1);
   assign swap_next     = transposed ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // map read data resolved against the touched flag of the row read
   always_comb begin
      case (state_ff)
         ST_WRI:  map_val = touched_ff[tgt_ff] ? map_rd_data : tgt_ff;
         default: map_val = touched_ff[idx_ff] ? map_rd_data : idx_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      load_cnt_in   = load_cnt_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      a_in          = a_ff;
      touched_in    = touched_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_source_in = rsp_source_ff;
      rsp_last_in   = rsp_last_ff;

      ram_ctl       = '0;
      piv_wr_addr   = load_cnt_ff[IDX_W-1:0];
      piv_wr_data   = load_cnt_ff[IDX_W-1:0];
      piv_rd_addr   = idx_ff;
      map_wr_addr   = idx_ff;
      map_wr_data   = map_val;
      map_rd_addr   = idx_ff;

      if (req_bus.pivot != '0 && req_bus.pivot <= PIVOT_MAX) begin
         piv_wr_data = pivot_m1[IDX_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ram_ctl.piv_we = 1'b1;
               if (cnt_next >= rows) begin
                  load_cnt_in = '0;
                  touched_in  = '0;
                  idx_in      = transposed ? rows_m1 : '0;
                  state_in    = ST_PIV;
               end else begin
                  load_cnt_in = cnt_next;
               end
            end
         end
         ST_PIV: begin
            ram_ctl.piv_re = 1'b1;
            state_in       = ST_RDA;
         end
         ST_RDA: begin
            tgt_in         = ({1'b0, piv_rd_data} >= rows) ? idx_ff : piv_rd_data;
            ram_ctl.map_re = 1'b1;
            state_in       = ST_RDB;
         end
         ST_RDB: begin
            a_in           = map_val;
            ram_ctl.map_re = 1'b1;
            map_rd_addr    = tgt_ff;
            state_in       = ST_WRI;
         end
         ST_WRI: begin
            ram_ctl.map_we     = 1'b1;
            touched_in[idx_ff] = 1'b1;
            state_in           = ST_WRT;
         end
         ST_WRT: begin
            ram_ctl.map_we     = 1'b1;
            map_wr_addr        = tgt_ff;
            map_wr_data        = a_ff;
            touched_in[tgt_ff] = 1'b1;
            if (swap_last) begin
               idx_in   = '0;
               state_in = ST_EMRD;
            end else begin
               ram_ctl.piv_re = 1'b1;
               piv_rd_addr    = swap_next;
               idx_in         = swap_next;
               state_in       = ST_RDA;
            end
         end
         ST_EMRD: begin
            ram_ctl.map_re = 1'b1;
            state_in       = ST_EMWAIT;
         end
         ST_EMWAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = ROW_INDEX_W'(idx_ff);
               rsp_source_in = touched_ff[idx_ff] ? SOURCE_ROW_W'(map_rd_data) : UNTOUCHED;
               rsp_last_in   = (idx_ff == rows_m1);
               if (idx_ff == rows_m1) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_ctl.map_re = 1'b1;
                  map_rd_addr    = idx_ff + 1'b1;
                  idx_in         = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_cnt_ff  <= '0;
         touched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         touched_ff   <= touched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      a_ff          <= a_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_source_ff <= rsp_source_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.row_index  = rsp_index_ff;
   assign rsp_bus.source_row = rsp_source_ff;
   assign rsp_bus.last_row   = rsp_last_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pivot_swaps_to_permutation. A table of directed
// steps and then random rounds of pivot words go in under random idling on
// both channels. The row_count and transposed registers are changed between
// rounds. Each permutation word that comes out is compared with the map
// that a local swap model builds from the pivots that were accepted, or,
// for directed steps with words > 0, with the map typed into the table.
module testbench import pstp_pkg::*; ();

   localparam int MAX_ROWS     = 64;
   localparam int RANDOM_ITEMS = 130;
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic        [ROW_INDEX_W-1:0]  row_index;
      logic signed [SOURCE_ROW_W-1:0] source_row;
      logic                           last_row;
   } map_word_type;

   typedef enum logic [1:0] {
      STEP_ROWS,
      STEP_TRANS,
      STEP_PIVOT
   } step_type;

   // words > 0: the map that this pivot completes is typed in (first rows)
   typedef struct packed {
      step_type                       kind;
      logic [PIVOT_W-1:0]             value;
      logic [1:0]                     words;
      logic signed [SOURCE_ROW_W-1:0] src0;
      logic signed [SOURCE_ROW_W-1:0] src1;
   } dir_step_type;

   localparam int DIR_STEPS = 31;

   dir_step_type directed [DIR_STEPS] = '{
      '{STEP_ROWS,  7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_TRANS, 7'd0,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd1,   2'd1, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd0,   2'd1, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd127, 2'd1, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd64,  2'd1, 7'sd0, 7'sd0},
      '{STEP_ROWS,  7'd2,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd2,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd2,   2'd2, 7'sd1, 7'sd0},
      '{STEP_PIVOT, 7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd2,   2'd2, 7'sd0, 7'sd1},
      '{STEP_TRANS, 7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd1,   2'd2, 7'sd1, 7'sd0},
      '{STEP_PIVOT, 7'd65,  2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd64,  2'd2, 7'sd0, 7'sd1},
      '{STEP_ROWS,  7'd0,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd42,  2'd1, 7'sd0, 7'sd0},
      '{STEP_TRANS, 7'd0,   2'd0, 7'sd0, 7'sd0},
      '{STEP_ROWS,  7'd127, 2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd5,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd3,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_ROWS,  7'd3,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd2,   2'd0, 7'sd0, 7'sd0},
      '{STEP_ROWS,  7'd4,   2'd0, 7'sd0, 7'sd0},
      '{STEP_TRANS, 7'd1,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd3,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd4,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd4,   2'd0, 7'sd0, 7'sd0},
      '{STEP_PIVOT, 7'd4,   2'd0, 7'sd0, 7'sd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   pstp_req_if req_if ();
   pstp_rsp_if rsp_if ();

   pivot_swaps_to_permutation #(
      .MAX_ROWS (MAX_ROWS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // swap model state
   logic [ROW_INDEX_W-1:0] swap_target [MAX_ROWS];
   logic [ROW_COUNT_W-1:0] pivots_loaded;
   logic [ROW_COUNT_W-1:0] row_count_reg;
   logic                   transposed_reg;

   map_word_type pending_map [$];
   int        errors;
   int        items_sent;
   bit        calm;
   bit        gaps_on;
   bit        stalls_on;
   int        stall_left;
   int        window;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int eff_rows(input logic [ROW_COUNT_W-1:0] rows);
      if (rows == '0) return 1;
      if (int'(rows) > MAX_ROWS) return MAX_ROWS;
      return int'(rows);
   endfunction

   // Store one pivot; when the round is full, build the map and, if emit is set, queue it.
   function automatic int load_pivot(input logic [PIVOT_W-1:0] pivot, input bit emit);
      logic [ROW_INDEX_W-1:0] pos;
      int                     n;
      int                     i;
      int                     k;
      int                     t;
      int                     a;
      int                     b;
      int                     perm [MAX_ROWS];
      pos = pivots_loaded[ROW_INDEX_W-1:0];
      if (pivot >= 7'd1 && int'(pivot) <= MAX_ROWS)
         swap_target[pos] = ROW_INDEX_W'(pivot - 7'd1);
      else
         swap_target[pos] = pos;
      pivots_loaded = pivots_loaded + 7'd1;
      n = eff_rows(row_count_reg);
      if (int'(pivots_loaded) < n) return 0;
      pivots_loaded = '0;
      for (i = 0; i < MAX_ROWS; i++) perm[i] = -1;
      for (k = 0; k < n; k++) begin
         i = transposed_reg ? n - 1 - k : k;
         t = int'(swap_target[i]);
         if (t >= n) t = i;
         a = (perm[i] < 0) ? i : perm[i];
         b = (perm[t] < 0) ? t : perm[t];
         perm[i] = b;
         perm[t] = a;
      end
      if (emit) begin
         for (i = 0; i < n; i++)
            pending_map.push_back('{row_index: ROW_INDEX_W'(i),
                                    source_row: SOURCE_ROW_W'(perm[i]),
                                    last_row: (i == n - 1)});
      end
      return n;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_map.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (index == CSR_ROW_COUNT)
         row_count_reg = data;
      else
         transposed_reg = data[0];
   endtask

   task automatic send_pivot(input logic [PIVOT_W-1:0] pivot, input bit emit);
      int gap;
      if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.pivot <= pivot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      void'(load_pivot(pivot, emit));
      items_sent++;
   endtask

   // result side stalls
   always @(negedge clock) begin
      window <= (window == 47) ? 0 : window + 1;
      if (window == 0) stalls_on <= ($urandom_range(0, 2) != 0);
      if (calm || reset) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 8);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      map_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_map.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: row %0d src %0d last %0d", rsp_if.row_index,
                        rsp_if.source_row, rsp_if.last_row);
         end else begin
            want = pending_map.pop_front();
            if (want.row_index !== rsp_if.row_index || want.source_row !== rsp_if.source_row
                || want.last_row !== rsp_if.last_row) begin
               errors++;
               if (errors <= 10)
                  $display("word mismatch: exp row %0d src %0d last %0d, got row %0d src %0d last %0d",
                           want.row_index, want.source_row, want.last_row, rsp_if.row_index,
                           rsp_if.source_row, rsp_if.last_row);
            end
         end
      end
   end

   initial begin
      int                 s;
      int                 i;
      int                 n;
      int                 count;
      int                 phase;
      logic [PIVOT_W-1:0] rows;
      logic [PIVOT_W-1:0] pivot;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_ROW_COUNT;
      csr_wr_data  = '0;
      req_if.valid = 1'b0;
      req_if.pivot = '0;
      rsp_if.ready = 1'b1;
      errors       = 0;
      items_sent   = 0;
      calm         = 1'b0;
      gaps_on      = 1'b1;
      stalls_on    = 1'b1;
      stall_left   = 0;
      window       = 0;
      pivots_loaded  = '0;
      row_count_reg  = ROW_COUNT_RESET;
      transposed_reg = 1'b0;
      for (i = 0; i < MAX_ROWS; i++) swap_target[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (s = 0; s < DIR_STEPS; s++) begin
         case (directed[s].kind)
            STEP_ROWS:  write_reg(CSR_ROW_COUNT, directed[s].value);
            STEP_TRANS: write_reg(CSR_TRANSPOSED, directed[s].value);
            default: begin
               send_pivot(directed[s].value, directed[s].words == 2'd0);
               for (i = 0; i < int'(directed[s].words); i++)
                  pending_map.push_back('{row_index: ROW_INDEX_W'(i),
                                          source_row: (i == 0) ? directed[s].src0
                                                               : directed[s].src1,
                                          last_row: (i == int'(directed[s].words) - 1)});
            end
         endcase
      end

      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (phase == 0)
            rows = 7'd64;
         else if (phase == 1)
            rows = PIVOT_W'($urandom_range(65, 127));
         else if (phase == 2)
            rows = 7'd0;
         else if ($urandom_range(0, 4) == 0)
            rows = PIVOT_W'($urandom_range(11, 20));
         else
            rows = PIVOT_W'($urandom_range(1, 10));
         write_reg(CSR_ROW_COUNT, rows);
         write_reg(CSR_TRANSPOSED, CSR_DATA_W'($urandom_range(0, 1)));
         gaps_on = ($urandom_range(0, 3) != 0);
         n = eff_rows(rows);
         count = (int'(pivots_loaded) >= n) ? 1 : n - int'(pivots_loaded);
         // now and then break a round off mid-load
         if (count > 1 && $urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
         for (i = 0; i < count; i++) begin
            if (items_sent >= RANDOM_ITEMS - 20) calm = 1'b1;
            case ($urandom_range(0, 9))
               0:       pivot = PIVOT_W'($urandom_range(0, 127));
               1, 2:    pivot = PIVOT_W'($urandom_range(1, 64));
               default: pivot = PIVOT_W'($urandom_range(1, n));
            endcase
            send_pivot(pivot, 1'b1);
         end
         phase++;
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_map.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
